[hw/rtl/mexp_pkg.sv]
// Shared types and constants for the modular exponentiation core.
// Holds the word, cell and payload types and the control encodings.
// No dependencies.
package mexp_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] word_t;

    // Item kinds on the input channel
    localparam logic [1:0] KIND_BASE  = 2'd0;
    localparam logic [1:0] KIND_EXP   = 2'd1;
    localparam logic [1:0] KIND_MOD   = 2'd2;
    localparam logic [1:0] KIND_START = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODULUS_WORDS  = 2'd0;
    localparam logic [1:0] CFG_BASE_WORDS     = 2'd1;
    localparam logic [1:0] CFG_EXPONENT_WORDS = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  word_index;
        logic [31:0] word_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_word;
        logic [5:0]  result_index;
        logic        last;
        logic        status;
    } out_item_t;

    // One word slice of every long operand
    typedef struct packed {
        word_t r;   // remainder word
        word_t d;   // trial difference word
        word_t m;   // modulus word
        word_t a;   // multiplier word, shifted out MSB first
        word_t b;   // multiplicand word
        word_t g;   // reduced base word
    } cell_t;

    typedef enum logic [3:0] {
        OP_ROTATE,
        OP_LOADM,
        OP_DOUBLE,
        OP_ADD,
        OP_SETUP_SQ,
        OP_SETUP_MUL,
        OP_RES_G,
        OP_SET_ACC,
        OP_RESOLVE,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t  op;
        logic first;
        logic bitin;
    } pe_ctrl_t;

    typedef struct packed {
        logic carry;
        logic borrow;
        logic acarry;
        logic sel;
    } pe_flags_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PASS,
        S_MCHECK,
        S_BFETCH,
        S_BLATCH,
        S_BPASS,
        S_BNEXT,
        S_EINIT,
        S_EFETCH,
        S_ELATCH,
        S_EBIT,
        S_MLOOP,
        S_MCHK,
        S_MCNT,
        S_ENEXT,
        S_FIN,
        S_FIN1,
        S_FIN2,
        S_OUT
    } state_t;

endpackage

[hw/rtl/mexp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mexp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/mexp_cell.sv]
// One word cell of the operand ring: holds a slice of every long operand.
// Depends on mexp_pkg.
module mexp_cell
    import mexp_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  logic  take_tail,
    input  cell_t from_next,
    input  cell_t from_pe,
    output cell_t q
);

    cell_t q_reg;

    // Advance toward the head; the tail cell takes the processed word
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= take_tail ? from_pe : from_next;
        end
    end

    assign q = q_reg;

endmodule

[hw/rtl/mexp_pe.sv]
// Word processing element at the head of the ring: double, add and
// trial-subtract one word per cycle, with carry and borrow held between words.
// Depends on mexp_pkg.
module mexp_pe
    import mexp_pkg::*;
(
    input  cell_t     head,
    input  word_t     mword,
    input  pe_ctrl_t  ctrl,
    input  pe_flags_t flags,
    output cell_t     nxt,
    output pe_flags_t flags_out
);

    word_t                cur;
    logic                 cin;
    logic                 bin;
    logic                 ain;
    logic [WORD_BITS:0]   pre;
    logic [WORD_BITS:0]   diff;

    always_comb
    begin
        cur  = flags.sel ? head.d : head.r;
        cin  = ctrl.first ? ((ctrl.op == OP_DOUBLE) ? ctrl.bitin : 1'b0) : flags.carry;
        bin  = ctrl.first ? 1'b0 : flags.borrow;
        ain  = ctrl.first ? 1'b0 : flags.acarry;
        nxt  = head;
        flags_out = flags;
        pre  = '0;
        diff = '0;
        case (ctrl.op)
            OP_DOUBLE:
            begin
                pre  = {1'b0, cur[WORD_BITS-2:0], cin};
                diff = pre - {1'b0, head.m} - {{WORD_BITS{1'b0}}, bin};
                nxt.r = pre[WORD_BITS-1:0];
                nxt.d = diff[WORD_BITS-1:0];
                nxt.a = {head.a[WORD_BITS-2:0], ain};
                flags_out.carry  = cur[WORD_BITS-1];
                flags_out.borrow = diff[WORD_BITS];
                flags_out.acarry = head.a[WORD_BITS-1];
                flags_out.sel    = cur[WORD_BITS-1] | ~diff[WORD_BITS];
            end
            OP_ADD:
            begin
                pre  = {1'b0, cur} + {1'b0, head.b} + {{WORD_BITS{1'b0}}, cin};
                diff = {1'b0, pre[WORD_BITS-1:0]} - {1'b0, head.m}
                     - {{WORD_BITS{1'b0}}, bin};
                nxt.r = pre[WORD_BITS-1:0];
                nxt.d = diff[WORD_BITS-1:0];
                flags_out.carry  = pre[WORD_BITS];
                flags_out.borrow = diff[WORD_BITS];
                flags_out.sel    = pre[WORD_BITS] | ~diff[WORD_BITS];
            end
            OP_LOADM:
            begin
                nxt.m = mword;
                nxt.r = '0;
                flags_out.sel = 1'b0;
            end
            OP_SETUP_SQ:
            begin
                nxt.a = cur;
                nxt.b = cur;
                nxt.r = '0;
                flags_out.sel = 1'b0;
            end
            OP_SETUP_MUL:
            begin
                nxt.a = cur;
                nxt.b = head.g;
                nxt.r = '0;
                flags_out.sel = 1'b0;
            end
            OP_RES_G:
            begin
                nxt.g = cur;
            end
            OP_SET_ACC:
            begin
                nxt.r = head.g;
                flags_out.sel = 1'b0;
            end
            OP_RESOLVE:
            begin
                nxt.r = cur;
                flags_out.sel = 1'b0;
            end
            OP_CLEAR:
            begin
                nxt.r = '0;
                flags_out.sel = 1'b0;
            end
            default:
            begin
                nxt = head;
            end
        endcase
    end

endmodule

[hw/rtl/modular_exponentiation_core.sv]
// Modular exponentiation core: top level with sequencer, operand stores and cell ring.
// Depends on mexp_pkg, mexp_ram, mexp_cell and mexp_pe.
//
// Load words (kind 0..2) are taken one per cycle. A start word computes
// base^exponent mod modulus by left-to-right square-and-multiply and then
// presents modulus_words result words, least significant first. Long operands
// live in a ring of word cells that rotates past a single word processing
// element, one word per cycle during a pass; every pass walks the n words of
// each operand (n = modulus_words). A modular multiply walks all n*32
// multiplier bits after a setup pass; each bit costs a doubling pass, and an
// add pass when the bit is set. Base reduction takes base_words*32 doubling
// passes, with a fetch per base word. Every exponent word in use is scanned
// bit by bit, most significant first, with a fetch per word; after the
// leading one each bit adds one modular squaring and, when set, one more
// modular multiply. The input is not ready while a computation runs or while
// result words wait to be taken. A zero modulus gives status 1 and zero words
// right after loading the modulus.
module modular_exponentiation_core
    import mexp_pkg::*;
#(
    parameter int MAX_WORDS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data
);

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam logic [6:0] MAXW = 7'(MAX_WORDS);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    state_t ret_reg, ret_next;
    logic   bitin_reg, bitin_next;

    logic [6:0] nm_cfg_reg, nb_cfg_reg, ne_cfg_reg;
    logic [6:0] nm, nb, ne;

    logic [5:0]       wc_reg, wc_next;
    logic [AW-1:0]    bw_reg, bw_next;
    logic [AW-1:0]    ew_reg, ew_next;
    logic [BIT_W-1:0] bc_reg, bc_next;
    logic [5:0]       mw_reg, mw_next;
    logic [BIT_W-1:0] mb_reg, mb_next;
    logic [5:0]       oc_reg, oc_next;
    word_t            sh_reg, sh_next;
    logic             leading_reg, leading_next;
    logic             mphase_reg, mphase_next;
    logic             mnz_reg, mnz_next;
    logic             abit_reg, abit_next;
    pe_flags_t        flags_reg, flags_next;

    logic in_acc, out_acc, pass_last, shift;
    logic load_ok;
    word_t base_rd, exp_rd, mod_rd;
    logic [AW-1:0] mod_raddr;

    cell_t     ring [MAX_WORDS];
    cell_t     pe_out;
    pe_ctrl_t  pe_ctrl;
    pe_flags_t pe_flags;

    function automatic logic [6:0] clamp_len(input logic [6:0] v, input logic [6:0] mx);
        logic [6:0] r;
        r = v;
        if (v == 7'd0)
        begin
            r = 7'd1;
        end
        else if (v > mx)
        begin
            r = mx;
        end
        return r;
    endfunction

    assign nm = clamp_len(nm_cfg_reg, MAXW);
    assign nb = clamp_len(nb_cfg_reg, MAXW);
    assign ne = clamp_len(ne_cfg_reg, MAXW);

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid & in_ready;
    assign out_valid = (state_reg == S_OUT);
    assign out_acc   = out_valid & out_ready;
    assign cfg_ready = 1'b1;
    assign pass_last = ({1'b0, wc_reg} == (nm - 7'd1));
    assign shift     = (state_reg == S_PASS) | out_acc;
    assign load_ok   = in_acc & (in_data.kind != KIND_START)
                     & (32'(in_data.word_index) < MAX_WORDS);

    // Operand stores
    assign mod_raddr = (state_reg == S_PASS) ? AW'(wc_reg + 6'd1) : '0;

    mexp_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_WORDS)) u_base_ram (
        .clk   (clk),
        .we    (load_ok & (in_data.kind == KIND_BASE)),
        .waddr (AW'(in_data.word_index)),
        .wdata (in_data.word_value),
        .raddr (bw_reg),
        .rdata (base_rd)
    );

    mexp_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_WORDS)) u_exp_ram (
        .clk   (clk),
        .we    (load_ok & (in_data.kind == KIND_EXP)),
        .waddr (AW'(in_data.word_index)),
        .wdata (in_data.word_value),
        .raddr (ew_reg),
        .rdata (exp_rd)
    );

    mexp_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_WORDS)) u_mod_ram (
        .clk   (clk),
        .we    (load_ok & (in_data.kind == KIND_MOD)),
        .waddr (AW'(in_data.word_index)),
        .wdata (in_data.word_value),
        .raddr (mod_raddr),
        .rdata (mod_rd)
    );

    // Cell ring and processing element
    assign pe_ctrl.op    = (state_reg == S_PASS) ? op_reg : OP_ROTATE;
    assign pe_ctrl.first = (wc_reg == 6'd0);
    assign pe_ctrl.bitin = bitin_reg;

    mexp_pe u_pe (
        .head      (ring[0]),
        .mword     (mod_rd),
        .ctrl      (pe_ctrl),
        .flags     (flags_reg),
        .nxt       (pe_out),
        .flags_out (pe_flags)
    );

    for (genvar k = 0; k < MAX_WORDS; k++)
    begin : g_cell
        cell_t from_next;
        if (k < MAX_WORDS - 1)
        begin : g_mid
            assign from_next = ring[k+1];
        end
        else
        begin : g_end
            assign from_next = pe_out;
        end
        mexp_cell u_cell (
            .clk       (clk),
            .shift     (shift),
            .take_tail (7'(k) == (nm - 7'd1)),
            .from_next (from_next),
            .from_pe   (pe_out),
            .q         (ring[k])
        );
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_cfg_reg <= 7'd1;
            nb_cfg_reg <= 7'd1;
            ne_cfg_reg <= 7'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MODULUS_WORDS:  nm_cfg_reg <= cfg_data;
                CFG_BASE_WORDS:     nb_cfg_reg <= cfg_data;
                CFG_EXPONENT_WORDS: ne_cfg_reg <= cfg_data;
                default:            nm_cfg_reg <= nm_cfg_reg;
            endcase
        end
    end

    // Next state and pass launches
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        ret_next   = ret_reg;
        bitin_next = bitin_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && in_data.kind == KIND_START)
                begin
                    state_next = S_PASS;
                    op_next    = OP_LOADM;
                    ret_next   = S_MCHECK;
                end
            end
            S_PASS:
            begin
                if (pass_last)
                begin
                    state_next = ret_reg;
                end
            end
            S_MCHECK:  state_next = mnz_reg ? S_BFETCH : S_OUT;
            S_BFETCH:  state_next = S_BLATCH;
            S_BLATCH:  state_next = S_BPASS;
            S_BPASS:
            begin
                state_next = S_PASS;
                op_next    = OP_DOUBLE;
                bitin_next = sh_reg[WORD_BITS-1];
                ret_next   = S_BNEXT;
            end
            S_BNEXT:
            begin
                if (bc_reg == BIT_W'(WORD_BITS - 1))
                begin
                    if (bw_reg == '0)
                    begin
                        state_next = S_PASS;
                        op_next    = OP_RES_G;
                        ret_next   = S_EINIT;
                    end
                    else
                    begin
                        state_next = S_BFETCH;
                    end
                end
                else
                begin
                    state_next = S_BPASS;
                end
            end
            S_EINIT:   state_next = S_EFETCH;
            S_EFETCH:  state_next = S_ELATCH;
            S_ELATCH:  state_next = S_EBIT;
            S_EBIT:
            begin
                if (leading_reg)
                begin
                    if (sh_reg[WORD_BITS-1])
                    begin
                        state_next = S_PASS;
                        op_next    = OP_SET_ACC;
                        ret_next   = S_ENEXT;
                    end
                    else
                    begin
                        state_next = S_ENEXT;
                    end
                end
                else
                begin
                    state_next = S_PASS;
                    op_next    = OP_SETUP_SQ;
                    ret_next   = S_MLOOP;
                end
            end
            S_MLOOP:
            begin
                state_next = S_PASS;
                op_next    = OP_DOUBLE;
                bitin_next = 1'b0;
                ret_next   = S_MCHK;
            end
            S_MCHK:
            begin
                if (abit_reg)
                begin
                    state_next = S_PASS;
                    op_next    = OP_ADD;
                    ret_next   = S_MCNT;
                end
                else
                begin
                    state_next = S_MCNT;
                end
            end
            S_MCNT:
            begin
                if (mb_reg == BIT_W'(WORD_BITS - 1) && {1'b0, mw_reg} == (nm - 7'd1))
                begin
                    if (!mphase_reg && sh_reg[WORD_BITS-1])
                    begin
                        state_next = S_PASS;
                        op_next    = OP_SETUP_MUL;
                        ret_next   = S_MLOOP;
                    end
                    else
                    begin
                        state_next = S_ENEXT;
                    end
                end
                else
                begin
                    state_next = S_MLOOP;
                end
            end
            S_ENEXT:
            begin
                if (bc_reg == BIT_W'(WORD_BITS - 1))
                begin
                    state_next = (ew_reg == '0) ? S_FIN : S_EFETCH;
                end
                else
                begin
                    state_next = S_EBIT;
                end
            end
            S_FIN:
            begin
                state_next = S_PASS;
                op_next    = leading_reg ? OP_CLEAR : OP_RESOLVE;
                ret_next   = leading_reg ? S_FIN1 : S_OUT;
            end
            S_FIN1:
            begin
                // 1 mod m: one doubling step of zero with a one shifted in
                state_next = S_PASS;
                op_next    = OP_DOUBLE;
                bitin_next = 1'b1;
                ret_next   = S_FIN2;
            end
            S_FIN2:
            begin
                state_next = S_PASS;
                op_next    = OP_RESOLVE;
                ret_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_acc && {1'b0, oc_reg} == (nm - 7'd1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Counters, bit shifters and pass flags
    always_comb
    begin
        wc_next      = 6'd0;
        bw_next      = bw_reg;
        ew_next      = ew_reg;
        bc_next      = bc_reg;
        mw_next      = mw_reg;
        mb_next      = mb_reg;
        oc_next      = oc_reg;
        sh_next      = sh_reg;
        leading_next = leading_reg;
        mphase_next  = mphase_reg;
        mnz_next     = mnz_reg;
        abit_next    = abit_reg;
        flags_next   = flags_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                mnz_next = 1'b0;
                oc_next  = 6'd0;
                bw_next  = AW'(nb - 7'd1);
                bc_next  = '0;
            end
            S_PASS:
            begin
                wc_next = pass_last ? 6'd0 : wc_reg + 6'd1;
                flags_next.carry  = pe_flags.carry;
                flags_next.borrow = pe_flags.borrow;
                flags_next.acarry = pe_flags.acarry;
                if (pass_last)
                begin
                    flags_next.sel = pe_flags.sel;
                    if (op_reg == OP_DOUBLE)
                    begin
                        abit_next = pe_flags.acarry;
                    end
                end
                if (op_reg == OP_LOADM && mod_rd != '0)
                begin
                    mnz_next = 1'b1;
                end
            end
            S_BLATCH:  sh_next = base_rd;
            S_BNEXT:
            begin
                sh_next = {sh_reg[WORD_BITS-2:0], 1'b0};
                bc_next = bc_reg + BIT_W'(1);
                if (bc_reg == BIT_W'(WORD_BITS - 1) && bw_reg != '0)
                begin
                    bw_next = bw_reg - AW'(1);
                end
            end
            S_EINIT:
            begin
                ew_next      = AW'(ne - 7'd1);
                bc_next      = '0;
                leading_next = 1'b1;
            end
            S_ELATCH:  sh_next = exp_rd;
            S_EBIT:
            begin
                if (leading_reg && sh_reg[WORD_BITS-1])
                begin
                    leading_next = 1'b0;
                end
                mphase_next = 1'b0;
                mw_next     = 6'd0;
                mb_next     = '0;
            end
            S_MCNT:
            begin
                if (mb_reg == BIT_W'(WORD_BITS - 1))
                begin
                    mb_next = '0;
                    mw_next = ({1'b0, mw_reg} == (nm - 7'd1)) ? 6'd0 : mw_reg + 6'd1;
                    if ({1'b0, mw_reg} == (nm - 7'd1))
                    begin
                        mphase_next = 1'b1;
                    end
                end
                else
                begin
                    mb_next = mb_reg + BIT_W'(1);
                end
            end
            S_ENEXT:
            begin
                sh_next = {sh_reg[WORD_BITS-2:0], 1'b0};
                bc_next = bc_reg + BIT_W'(1);
                if (bc_reg == BIT_W'(WORD_BITS - 1) && ew_reg != '0)
                begin
                    ew_next = ew_reg - AW'(1);
                end
            end
            S_OUT:
            begin
                if (out_acc)
                begin
                    oc_next = oc_reg + 6'd1;
                end
            end
            default:
            begin
                wc_next = 6'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_ROTATE;
            ret_reg     <= S_IDLE;
            bitin_reg   <= 1'b0;
            wc_reg      <= 6'd0;
            bw_reg      <= '0;
            ew_reg      <= '0;
            bc_reg      <= '0;
            mw_reg      <= 6'd0;
            mb_reg      <= '0;
            oc_reg      <= 6'd0;
            leading_reg <= 1'b1;
            mphase_reg  <= 1'b0;
            mnz_reg     <= 1'b0;
            abit_reg    <= 1'b0;
            flags_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            ret_reg     <= ret_next;
            bitin_reg   <= bitin_next;
            wc_reg      <= wc_next;
            bw_reg      <= bw_next;
            ew_reg      <= ew_next;
            bc_reg      <= bc_next;
            mw_reg      <= mw_next;
            mb_reg      <= mb_next;
            oc_reg      <= oc_next;
            leading_reg <= leading_next;
            mphase_reg  <= mphase_next;
            mnz_reg     <= mnz_next;
            abit_reg    <= abit_next;
            flags_reg   <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

    // Result word comes straight from the head cell
    always_comb
    begin
        out_data.result_word  = mnz_reg ? ring[0].r : '0;
        out_data.result_index = oc_reg;
        out_data.last         = ({1'b0, oc_reg} == (nm - 7'd1));
        out_data.status       = ~mnz_reg;
    end

    a_start_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_data.kind == KIND_START) |=> !in_ready)
        else $error("input ready right after a start word");

    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && out_data.last) |=> in_ready)
        else $error("input not ready after the last result word");

    a_zero_status_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status) |-> (out_data.result_word == '0))
        else $error("nonzero word with divide-by-zero status");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result words pending");

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for modular_exponentiation_core: loads operand words, starts
// exponentiations and checks every result word against a big-integer predictor.
// Depends on mexp_pkg and the core RTL.
module tb_top
    import mexp_pkg::*;
();

    localparam int LIMIT = 600000;

    typedef bit [4095:0] bignum_t;

    class modexp_scoreboard;
        bit [31:0]  base_mem [64];
        bit [31:0]  exp_mem [64];
        bit [31:0]  mod_mem [64];
        bit [6:0]   len_reg [3];
        out_item_t  expected_q [$];
        int         fails;
        int         words_seen;
        int         starts;

        function new();
            len_reg = '{7'd1, 7'd1, 7'd1};
            fails = 0;
            words_seen = 0;
            starts = 0;
        endfunction

        function int span(int r);
            if (len_reg[r] == 0)
                return 1;
            if (len_reg[r] > 64)
                return 64;
            return len_reg[r];
        endfunction

        function void set_reg(logic [1:0] idx, logic [6:0] val);
            len_reg[idx] = val;
        endfunction

        function bignum_t join_words(bit [31:0] mem [64], int cnt);
            bignum_t v;
            v = '0;
            for (int k = cnt - 1; k >= 0; k--)
                v = (v << 32) | bignum_t'(mem[k]);
            return v;
        endfunction

        function void note_word(in_item_t w);
            bignum_t m, g, e, acc;
            int nm;
            int top;
            out_item_t r;
            case (w.kind)
                KIND_BASE: base_mem[w.word_index] = w.word_value;
                KIND_EXP:  exp_mem[w.word_index] = w.word_value;
                KIND_MOD:  mod_mem[w.word_index] = w.word_value;
                default:
                begin
                    starts++;
                    nm = span(CFG_MODULUS_WORDS);
                    m = join_words(mod_mem, nm);
                    acc = '0;
                    if (m != 0)
                    begin
                        g = join_words(base_mem, span(CFG_BASE_WORDS)) % m;
                        e = join_words(exp_mem, span(CFG_EXPONENT_WORDS));
                        top = -1;
                        for (int i = 0; i < 2048; i++)
                            if (e[i])
                                top = i;
                        if (top < 0)
                            acc = (m == 1) ? 0 : 1;
                        else
                        begin
                            acc = g;
                            // left to right over the remaining exponent bits
                            for (int i = top - 1; i >= 0; i--)
                            begin
                                acc = (acc * acc) % m;
                                if (e[i])
                                    acc = (acc * g) % m;
                            end
                        end
                    end
                    for (int k = 0; k < nm; k++)
                    begin
                        r.result_word  = acc[k*32 +: 32];
                        r.result_index = 6'(k);
                        r.last         = (k == nm - 1);
                        r.status       = (m == 0);
                        expected_q.push_back(r);
                    end
                end
            endcase
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            fails++;
            $display("ERROR: %s got %0h, expected %0h", what, got, want);
        endtask

        task check_word(out_item_t r);
            out_item_t x;
            words_seen++;
            if (expected_q.size() == 0)
            begin
                report("unexpected result word", r.result_word, 0);
                return;
            end
            x = expected_q.pop_front();
            if (r.result_word !== x.result_word)
                report("result_word", r.result_word, x.result_word);
            if (r.result_index !== x.result_index)
                report("result_index", r.result_index, x.result_index);
            if (r.last !== x.last)
                report("last", r.last, x.last);
            if (r.status !== x.status)
                report("status", r.status, x.status);
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;

    modexp_scoreboard sb;
    int send_idle;
    int recv_idle;
    int quiet_cycles;
    int words_sent;

    modular_exponentiation_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // result side: random back-pressure, check on every accepted word, watchdog
    always @(negedge clk)
        out_ready = rst_n && ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_word(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", LIMIT);
                $display("modular_exponentiation_core: mismatch");
                $finish;
            end
        end
    end

    // called at a falling edge; valid stays high after acceptance until the next
    // word or until hold_input drops it
    task send(logic [1:0] k, logic [5:0] idx, logic [31:0] v);
        if ($urandom_range(0, 99) < send_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
            while ($urandom_range(0, 99) < send_idle)
                @(negedge clk);
        end
        in_valid = 1'b1;
        in_data = '{kind: k, word_index: idx, word_value: v};
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(in_data);
        words_sent++;
        @(negedge clk);
    endtask

    task hold_input();
        in_valid = 1'b0;
        in_data = '0;
    endtask

    task drain();
        hold_input();
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task write_reg(logic [1:0] idx, logic [6:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task set_lengths(logic [6:0] nm, logic [6:0] nb, logic [6:0] ne);
        write_reg(CFG_MODULUS_WORDS, nm);
        write_reg(CFG_BASE_WORDS, nb);
        write_reg(CFG_EXPONENT_WORDS, ne);
    endtask

    task fill(logic [1:0] k, int cnt, bit zeros);
        for (int i = 0; i < cnt; i++)
            send(k, 6'(i), zeros ? 32'd0 : $urandom());
    endtask

    // short random exponent word, at most 24 significant bits, keeps each start short
    function logic [31:0] short_exp();
        return $urandom() >> $urandom_range(8, 31);
    endfunction

    // well-formed load of every word in use, then start
    task full_job(int nm, int nb, int ne);
        logic [31:0] w;
        for (int i = 0; i < nb; i++)
            send(KIND_BASE, 6'(i), $urandom());
        for (int i = 0; i < ne; i++)
            send(KIND_EXP, 6'(i), (i == 0) ? short_exp() : 32'd0);
        for (int i = 0; i < nm; i++)
        begin
            w = $urandom();
            if ($urandom_range(0, 9) == 0)
                w = 32'd0;
            send(KIND_MOD, 6'(i), w);
        end
        send(KIND_START, 6'($urandom()), $urandom());
    endtask

    task random_phase(int quota);
        int nm, nb, ne, stop;
        nm = $urandom_range(1, 3);
        nb = $urandom_range(1, 4);
        ne = $urandom_range(1, 2);
        set_lengths(7'(nm), 7'(nb), 7'(ne));
        stop = words_sent + quota;
        full_job(nm, nb, ne);
        while (words_sent < stop)
        begin
            if ($urandom_range(0, 3) != 0)
                full_job(nm, nb, ne);
            else
            begin
                // noise: stray loads anywhere, then a start on whatever is stored
                repeat ($urandom_range(1, 4))
                    case ($urandom_range(0, 2))
                        0: send(KIND_BASE, 6'($urandom()), $urandom());
                        1: send(KIND_EXP, 6'($urandom()), short_exp());
                        default: send(KIND_MOD, 6'($urandom()), $urandom());
                    endcase
                send(KIND_START, 6'($urandom()), $urandom());
            end
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle = 25;
        recv_idle = 53;
        quiet_cycles = 0;
        words_sent = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed, one-word operands
        send(KIND_BASE, 0, 32'hFFFF_FFFF);
        send(KIND_EXP, 0, 32'hFFFF_FFFF);
        send(KIND_MOD, 0, 32'hFFFF_FFFF);
        send(KIND_START, 0, 0);
        send(KIND_MOD, 0, 32'd0);
        send(KIND_START, 6'h3F, 32'hFFFF_FFFF);
        send(KIND_MOD, 0, 32'd1);
        send(KIND_EXP, 0, 32'd0);
        send(KIND_START, 0, 0);
        send(KIND_MOD, 0, 32'd7);
        send(KIND_START, 0, 0);
        send(KIND_BASE, 0, 32'd0);
        send(KIND_EXP, 0, 32'd5);
        send(KIND_START, 0, 0);
        send(KIND_BASE, 0, 32'd100);
        send(KIND_EXP, 0, 32'd1);
        send(KIND_START, 0, 0);
        send(KIND_BASE, 0, 32'hFFFF_FFFE);
        send(KIND_MOD, 0, 32'hFFFF_FFFF);
        send(KIND_EXP, 0, 32'h8000_0000);
        send(KIND_START, 0, 0);
        send(KIND_BASE, 6'h3F, 32'h8000_0001);
        drain();

        // length extremes: 127 clamps to 64, 0 clamps to 1
        set_lengths(7'd127, 7'd0, 7'd0);
        fill(KIND_MOD, 64, 1'b1);
        send(KIND_START, 0, 0);
        send(KIND_MOD, 6'h3F, 32'h8000_0001);
        send(KIND_EXP, 0, 32'd0);
        send(KIND_START, 0, 0);
        send(KIND_EXP, 0, 32'd1);
        send(KIND_START, 0, 0);
        drain();
        set_lengths(7'd1, 7'd8, 7'd2);
        fill(KIND_BASE, 8, 1'b0);
        fill(KIND_EXP, 2, 1'b1);
        send(KIND_EXP, 0, 32'h0000_B5C3);
        send(KIND_MOD, 0, 32'hF000_0007);
        send(KIND_START, 0, 0);
        drain();
        set_lengths(7'd64, 7'd1, 7'd1);
        drain();

        random_phase(8);
        random_phase(8);
        send_idle = 53;
        recv_idle = 25;
        random_phase(8);
        random_phase(8);
        send_idle = 0;
        recv_idle = 0;
        random_phase(8);
        random_phase(8);

        $display("run covered %0d input words, %0d starts, %0d result words",
                 words_sent, sb.starts, sb.words_seen);
        $display("lengths 0..127 incl. clamping, zero modulus/exponent, long base reduction");
        if (sb.fails == 0 && sb.expected_q.size() == 0)
            $display("modular_exponentiation_core: match");
        else
            $display("modular_exponentiation_core: mismatch");
        $finish;
    end
endmodule
